@@ design/pic_pkg.sv @@
// ----------------------------------------------------------------------------
// pic_pkg
// Shared widths, register indexes, reset values and sequencer types for the
// clamped PI controller.
// ----------------------------------------------------------------------------
package pic_pkg;

   localparam int FRAC_BITS_DEFAULT = 8;

   localparam int CFG_W       = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int DATA_W      = 16;
   localparam int GAIN_W      = 16;
   localparam int ERR_W       = 17;
   localparam int MAG_W       = 48;
   localparam int ACC_W       = 50;
   localparam int LIMIT_W     = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROPORTIONAL_GAIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_TIME     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_PERIOD     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_UPPER    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_LOWER    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_LIMIT      = 3'd5;

   localparam logic        [GAIN_W-1:0]  RST_PROPORTIONAL_GAIN = 16'd256;
   localparam logic        [GAIN_W-1:0]  RST_INTEGRAL_TIME     = 16'd256;
   localparam logic        [GAIN_W-1:0]  RST_SAMPLE_PERIOD     = 16'd256;
   localparam logic signed [DATA_W-1:0]  RST_INTEGRAL_UPPER    = 16'sd12800;
   localparam logic signed [DATA_W-1:0]  RST_INTEGRAL_LOWER    = -16'sd5120;
   localparam logic        [LIMIT_W-1:0] RST_OUTPUT_LIMIT      = 15'd17920;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_GAIN,
      ST_ERR,
      ST_ABS_ERR,
      ST_MUL_ERR,
      ST_SIGN_PROD,
      ST_DIVIDEND,
      ST_DIV,
      ST_INTEGRAL,
      ST_CLAMP_HI,
      ST_CLAMP_LO,
      ST_SUM,
      ST_NEG_LIMIT,
      ST_LIMIT_HI,
      ST_LIMIT_LO,
      ST_WRITE
   } pic_state_type;

   typedef struct packed {
      pic_state_type state;
      logic          load_rsp;
   } pic_ctrl_type;

endpackage

@@ design/pi_controller_clamped.sv @@
// ----------------------------------------------------------------------------
// pi_controller_clamped
// Fixed-point PI controller with a clamped integral and a saturated output.
//
// A request carries a setpoint and a measurement (signed, FRAC_BITS
// fractional bits). Each request gives exactly one response, control_output,
// which is P plus the clamped integral, saturated to +/- output_limit.
// Gains, clamp bounds and the limit are written through the csr_ port; the
// user must write them only while no request is in flight, as the block
// does not enforce it. A write to an unlisted index is dropped.
// One shared adder does all the work under a step sequencer: 16 steps for
// Kp*Ts, 17 for the error product, 48 - FRAC_BITS for the divide by Ti and
// a dozen single steps. rsp_valid rises when the result moves to the output
// register in the final step; a new request is taken in the cycle after
// that, so the block works one request at a time. While rsp_stall holds the
// output register the block may take and work the next request, then waits
// in its final step until the register frees up.
// Reset loads the register defaults, clears the stored integral and empties
// the output register.
// ----------------------------------------------------------------------------
module pi_controller_clamped
   import pic_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_setpoint,
   input  logic signed [DATA_W-1:0] req_measurement,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_control_output,

   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]         csr_write_data
);

   localparam int DIV_W = MAG_W - FRAC_BITS;

   pic_ctrl_type ctrl;
   logic         req_accept;
   logic         out_free;

   logic        [GAIN_W-1:0]  kp_ff, kp_in;
   logic        [GAIN_W-1:0]  ti_ff, ti_in;
   logic        [GAIN_W-1:0]  ts_ff, ts_in;
   logic signed [DATA_W-1:0]  upper_ff, upper_in;
   logic signed [DATA_W-1:0]  lower_ff, lower_in;
   logic        [LIMIT_W-1:0] limit_ff, limit_in;
   logic signed [DATA_W-1:0]  isum_ff, isum_in;

   logic signed [DATA_W-1:0]  sp_ff, sp_in;
   logic signed [DATA_W-1:0]  ms_ff, ms_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   mcand_ff, mcand_in;
   logic        [ERR_W-1:0]   mplier_ff, mplier_in;
   logic                      neg_ff, neg_in;
   logic signed [ACC_W-1:0]   p_ff, p_in;
   logic        [DIV_W-1:0]   dvd_ff, dvd_in;
   logic        [GAIN_W-1:0]  rem_ff, rem_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_out_ff, rsp_out_in;

   logic signed [ACC_W-1:0]   alu_a, alu_b, alu_res;
   logic                      alu_inv, alu_cin;
   logic                      res_neg;
   logic        [GAIN_W-1:0]  ti_eff;
   logic        [ERR_W-1:0]   rem_shift;

   assign req_stall          = (ctrl.state != ST_IDLE);
   assign req_accept         = req_valid && !req_stall;
   assign out_free           = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_control_output = rsp_out_ff;

   // zero integral time acts as the smallest step
   assign ti_eff    = (ti_ff == '0) ? GAIN_W'(1) : ti_ff;
   assign rem_shift = {rem_ff, dvd_ff[DIV_W-1]};
   assign res_neg   = alu_res[ACC_W-1];

   pic_sequencer #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .out_free (out_free),
      .ctrl     (ctrl)
   );

   pic_alu u_alu (
      .operand_a (alu_a),
      .operand_b (alu_b),
      .invert_b  (alu_inv),
      .carry_in  (alu_cin),
      .result    (alu_res)
   );

   // shared adder operand selection
   always_comb begin
      alu_a   = acc_ff;
      alu_b   = '0;
      alu_inv = 1'b0;
      alu_cin = 1'b0;
      case (ctrl.state)
         ST_MUL_GAIN, ST_MUL_ERR: begin
            alu_b = mplier_ff[0] ? mcand_ff : '0;
         end
         ST_ERR: begin
            alu_a   = ACC_W'(sp_ff);
            alu_b   = ACC_W'(ms_ff);
            alu_inv = 1'b1;
            alu_cin = 1'b1;
         end
         ST_ABS_ERR: begin
            alu_a   = '0;
            alu_inv = acc_ff[ACC_W-1];
            alu_cin = acc_ff[ACC_W-1];
            alu_b   = acc_ff;
         end
         ST_SIGN_PROD: begin
            alu_a   = '0;
            alu_b   = acc_ff;
            alu_inv = neg_ff;
            alu_cin = neg_ff;
         end
         ST_DIVIDEND: begin
            alu_a   = '0;
            alu_b   = acc_ff >>> FRAC_BITS;
            alu_inv = neg_ff;
            alu_cin = neg_ff;
         end
         ST_DIV: begin
            alu_a   = $signed(ACC_W'(rem_shift));
            alu_b   = $signed(ACC_W'(ti_eff));
            alu_inv = 1'b1;
            alu_cin = 1'b1;
         end
         ST_INTEGRAL: begin
            // floor on a negative quotient: -q - 1 when the divide left a remainder
            alu_a   = ACC_W'(isum_ff);
            alu_b   = $signed(ACC_W'(dvd_ff));
            alu_inv = neg_ff;
            alu_cin = neg_ff && (rem_ff == '0);
         end
         ST_CLAMP_HI: begin
            alu_a   = ACC_W'(upper_ff);
            alu_inv = 1'b1;
            alu_cin = 1'b1;
         end
         ST_CLAMP_LO: begin
            alu_b   = ACC_W'(lower_ff);
            alu_inv = 1'b1;
            alu_cin = 1'b1;
         end
         ST_SUM: begin
            alu_a = p_ff;
            alu_b = acc_ff;
         end
         ST_NEG_LIMIT: begin
            alu_a   = '0;
            alu_b   = $signed(ACC_W'(limit_ff));
            alu_inv = 1'b1;
            alu_cin = 1'b1;
         end
         ST_LIMIT_HI: begin
            alu_a   = $signed(ACC_W'(limit_ff));
            alu_inv = 1'b1;
            alu_cin = 1'b1;
         end
         ST_LIMIT_LO: begin
            alu_b = $signed(ACC_W'(limit_ff));
         end
         default: begin
            alu_a = acc_ff;
         end
      endcase
      if (ctrl.state == ST_ABS_ERR || ctrl.state == ST_CLAMP_HI ||
          ctrl.state == ST_LIMIT_HI) begin
         alu_b = acc_ff;
      end
   end

   // datapath next values
   always_comb begin
      kp_in        = kp_ff;
      ti_in        = ti_ff;
      ts_in        = ts_ff;
      upper_in     = upper_ff;
      lower_in     = lower_ff;
      limit_in     = limit_ff;
      isum_in      = isum_ff;
      sp_in        = sp_ff;
      ms_in        = ms_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      neg_in       = neg_ff;
      p_in         = p_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_out_in   = rsp_out_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_PROPORTIONAL_GAIN: kp_in    = csr_write_data;
            CSR_INTEGRAL_TIME:     ti_in    = csr_write_data;
            CSR_SAMPLE_PERIOD:     ts_in    = csr_write_data;
            CSR_INTEGRAL_UPPER:    upper_in = $signed(csr_write_data);
            CSR_INTEGRAL_LOWER:    lower_in = $signed(csr_write_data);
            CSR_OUTPUT_LIMIT:      limit_in = csr_write_data[LIMIT_W-1:0];
            default: begin
               kp_in = kp_ff;
            end
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (ctrl.state)
         ST_IDLE: begin
            if (req_accept) begin
               sp_in     = req_setpoint;
               ms_in     = req_measurement;
               acc_in    = '0;
               mcand_in  = $signed(ACC_W'(kp_ff));
               mplier_in = ERR_W'(ts_ff);
            end
         end
         ST_MUL_GAIN, ST_MUL_ERR: begin
            acc_in    = alu_res;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
         end
         ST_ERR: begin
            mcand_in = acc_ff;
            acc_in   = alu_res;
         end
         ST_ABS_ERR: begin
            neg_in    = acc_ff[ACC_W-1];
            mplier_in = alu_res[ERR_W-1:0];
            acc_in    = '0;
         end
         ST_SIGN_PROD: begin
            acc_in = alu_res;
         end
         ST_DIVIDEND: begin
            p_in   = acc_ff >>> (2 * FRAC_BITS);
            dvd_in = alu_res[DIV_W-1:0];
            rem_in = '0;
         end
         ST_DIV: begin
            dvd_in = {dvd_ff[DIV_W-2:0], !res_neg};
            rem_in = res_neg ? rem_shift[GAIN_W-1:0] : alu_res[GAIN_W-1:0];
         end
         ST_INTEGRAL, ST_SUM: begin
            acc_in = alu_res;
         end
         ST_CLAMP_HI: begin
            if (res_neg) begin
               acc_in = ACC_W'(upper_ff);
            end
         end
         ST_CLAMP_LO: begin
            if (res_neg) begin
               acc_in  = ACC_W'(lower_ff);
               isum_in = lower_ff;
            end else begin
               isum_in = acc_ff[DATA_W-1:0];
            end
         end
         ST_NEG_LIMIT: begin
            mcand_in = alu_res;
         end
         ST_LIMIT_HI: begin
            if (res_neg) begin
               acc_in = $signed(ACC_W'(limit_ff));
            end
         end
         ST_LIMIT_LO: begin
            if (res_neg) begin
               acc_in = mcand_ff;
            end
         end
         ST_WRITE: begin
            if (ctrl.load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_out_in   = acc_ff[DATA_W-1:0];
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= RST_PROPORTIONAL_GAIN;
         ti_ff        <= RST_INTEGRAL_TIME;
         ts_ff        <= RST_SAMPLE_PERIOD;
         upper_ff     <= RST_INTEGRAL_UPPER;
         lower_ff     <= RST_INTEGRAL_LOWER;
         limit_ff     <= RST_OUTPUT_LIMIT;
         isum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kp_ff        <= kp_in;
         ti_ff        <= ti_in;
         ts_ff        <= ts_in;
         upper_ff     <= upper_in;
         lower_ff     <= lower_in;
         limit_ff     <= limit_in;
         isum_ff      <= isum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sp_ff      <= sp_in;
      ms_ff      <= ms_in;
      acc_ff     <= acc_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      neg_ff     <= neg_in;
      p_ff       <= p_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      rsp_out_ff <= rsp_out_in;
   end

   a_start_multiply: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> ctrl.state == ST_MUL_GAIN)
      else $error("request accepted but multiply did not start");

   a_remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      ctrl.state == ST_DIV |-> rem_ff < ti_eff)
      else $error("divide remainder not below integral time");

   a_output_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_out_ff) <= $signed({1'b0, limit_ff}) &&
                        $signed(rsp_out_ff) >= -$signed({1'b0, limit_ff})))
      else $error("response outside output limit");

   a_load_response: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_rsp |=> rsp_valid_ff && rsp_out_ff == $past(acc_ff[DATA_W-1:0]))
      else $error("response register not loaded from accumulator");

endmodule

@@ design/pic_alu.sv @@
// ----------------------------------------------------------------------------
// pic_alu
// Shared adder/subtractor used by every computing step of the controller sequence:
// shift-add multiply, restoring divide, negation, sums and compares.
// ----------------------------------------------------------------------------
module pic_alu
   import pic_pkg::*;
(
   input  logic signed [ACC_W-1:0] operand_a,
   input  logic signed [ACC_W-1:0] operand_b,
   input  logic                    invert_b,
   input  logic                    carry_in,
   output logic signed [ACC_W-1:0] result
);

   logic signed [ACC_W-1:0] b_eff;

   assign b_eff  = invert_b ? ~operand_b : operand_b;
   assign result = operand_a + b_eff + $signed({{(ACC_W-1){1'b0}}, carry_in});

endmodule

@@ design/pic_sequencer.sv @@
// ----------------------------------------------------------------------------
// pic_sequencer
// Step sequencer for the controller: walks the multiply, divide, clamp and
// saturate steps and counts the iterations of the looping steps.
// ----------------------------------------------------------------------------
module pic_sequencer
   import pic_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         out_free,
   output pic_ctrl_type ctrl
);

   localparam int DIV_STEPS = MAG_W - FRAC_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   pic_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             last;
   logic             looping;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      last          = 1'b0;
      looping       = 1'b0;
      ctrl.load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL_GAIN;
            end
         end
         ST_MUL_GAIN: begin
            looping = 1'b1;
            last    = (count_ff == CNT_W'(GAIN_W - 1));
            if (last) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR:       state_in = ST_ABS_ERR;
         ST_ABS_ERR:   state_in = ST_MUL_ERR;
         ST_MUL_ERR: begin
            looping = 1'b1;
            last    = (count_ff == CNT_W'(ERR_W - 1));
            if (last) begin
               state_in = ST_SIGN_PROD;
            end
         end
         ST_SIGN_PROD: state_in = ST_DIVIDEND;
         ST_DIVIDEND:  state_in = ST_DIV;
         ST_DIV: begin
            looping = 1'b1;
            last    = (count_ff == CNT_W'(DIV_STEPS - 1));
            if (last) begin
               state_in = ST_INTEGRAL;
            end
         end
         ST_INTEGRAL:  state_in = ST_CLAMP_HI;
         ST_CLAMP_HI:  state_in = ST_CLAMP_LO;
         ST_CLAMP_LO:  state_in = ST_SUM;
         ST_SUM:       state_in = ST_NEG_LIMIT;
         ST_NEG_LIMIT: state_in = ST_LIMIT_HI;
         ST_LIMIT_HI:  state_in = ST_LIMIT_LO;
         ST_LIMIT_LO:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (out_free) begin
               ctrl.load_rsp = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      count_in   = (looping && !last) ? count_ff + 1'b1 : '0;
      ctrl.state = state_ff;
   end

endmodule

@@ test/tb_pi_controller_clamped.sv @@
// ----------------------------------------------------------------------------
// tb_pi_controller_clamped
// Self-checking bench for the clamped PI controller. A stimulus table walks
// the field extremes from reset, then bursts of random requests run under a
// range of gain, clamp and limit settings, crossed bounds, zero integral time
// and a zero output limit among them. A local fixed-point model predicts
// each response the table leaves open; all are compared in order on exit.
// ----------------------------------------------------------------------------
module tb_pi_controller_clamped
   import pic_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          FRAC        = FRAC_BITS_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int          HOLD_CYCLES = 600;

   typedef struct packed {
      logic signed [DATA_W-1:0] setpoint;
      logic signed [DATA_W-1:0] measurement;
      logic                     known;
      logic signed [DATA_W-1:0] value;
   } control_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_setpoint = '0;
   logic signed [DATA_W-1:0] req_measurement = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_control_output;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CFG_W-1:0]         csr_write_data = '0;

   // controller image
   logic [GAIN_W-1:0]        gain_kp;
   logic [GAIN_W-1:0]        time_ti;
   logic [GAIN_W-1:0]        period_ts;
   logic signed [DATA_W-1:0] bound_upper;
   logic signed [DATA_W-1:0] bound_lower;
   logic [LIMIT_W-1:0]       output_cap;
   logic signed [DATA_W-1:0] integral_image;

   logic signed [DATA_W-1:0] control_expected [$];
   control_row_type          request_rows [$];
   control_row_type          accepted_row;
   logic signed [DATA_W-1:0] wanted_output;
   int                       mismatch_count = 0;
   int unsigned              cycle_count = 0;
   bit                       quiet = 1'b0;
   bit                       hold_pending = 1'b0;

   control_row_type directed_rows [16] = '{
      '{16'sd0,      16'sd0,      1'b1, 16'sd0},
      '{16'sd32767,  16'sh8000,   1'b1, 16'sd17920},
      '{16'sh8000,   16'sd32767,  1'b1, -16'sd17920},
      '{16'sd0,      16'sd0,      1'b1, -16'sd5120},
      '{16'sh8000,   16'sh8000,   1'b1, -16'sd5120},
      '{16'sd32767,  16'sd32767,  1'b1, -16'sd5120},
      '{16'sd256,    16'sd0,      1'b0, 16'sd0},
      '{16'sd0,      16'sd256,    1'b0, 16'sd0},
      '{-16'sd1,     16'sd0,      1'b0, 16'sd0},
      '{16'sd0,      -16'sd1,     1'b0, 16'sd0},
      '{16'sh5555,   16'shAAAA,   1'b0, 16'sd0},
      '{16'shAAAA,   16'sh5555,   1'b0, 16'sd0},
      '{16'sd1,      16'sd0,      1'b0, 16'sd0},
      '{16'sd32767,  16'sd0,      1'b0, 16'sd0},
      '{16'sh8000,   16'sd0,      1'b0, 16'sd0},
      '{16'sd0,      16'sd32767,  1'b0, 16'sd0}
   };

   pi_controller_clamped dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_setpoint       (req_setpoint),
      .req_measurement    (req_measurement),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_control_output (rsp_control_output),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #4 clock = ~clock;
   end

   function automatic longint floor_div(input longint num, input longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic logic signed [DATA_W-1:0] predict_control(
      input logic signed [DATA_W-1:0] setpoint,
      input logic signed [DATA_W-1:0] measurement
   );
      longint err;
      longint gain;
      longint prod;
      longint ti;
      longint p_part;
      longint i_part;
      longint y;
      longint cap;
      err    = longint'(setpoint) - longint'(measurement);
      gain   = {48'd0, gain_kp} * {48'd0, period_ts};
      prod   = gain * err;
      ti     = (time_ti == '0) ? 64'sd1 : {48'd0, time_ti};
      p_part = floor_div(prod, 64'sd1 <<< (2 * FRAC));
      i_part = floor_div(prod, ti <<< FRAC) + longint'(integral_image);
      if (i_part > longint'(bound_upper)) begin
         i_part = longint'(bound_upper);
      end
      if (i_part < longint'(bound_lower)) begin
         i_part = longint'(bound_lower);
      end
      integral_image = i_part[DATA_W-1:0];
      cap = {49'd0, output_cap};
      y = p_part + i_part;
      if (y > cap) begin
         y = cap;
      end
      if (y < -cap) begin
         y = -cap;
      end
      return y[DATA_W-1:0];
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] index,
                                          input logic [CFG_W-1:0] data);
      case (index)
         CSR_PROPORTIONAL_GAIN: gain_kp = data;
         CSR_INTEGRAL_TIME:     time_ti = data;
         CSR_SAMPLE_PERIOD:     period_ts = data;
         CSR_INTEGRAL_UPPER:    bound_upper = data;
         CSR_INTEGRAL_LOWER:    bound_lower = data;
         CSR_OUTPUT_LIMIT:      output_cap = data[LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      apply_register(index, data);
   endtask

   // unlisted indexes get junk that must be dropped
   task automatic set_config(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] ti,
                             input logic [CFG_W-1:0] ts, input logic [CFG_W-1:0] upper,
                             input logic [CFG_W-1:0] lower, input logic [CFG_W-1:0] cap);
      write_register(CSR_PROPORTIONAL_GAIN, kp);
      write_register(CSR_INTEGRAL_TIME, ti);
      write_register(CSR_SAMPLE_PERIOD, ts);
      write_register(CSR_INTEGRAL_UPPER, upper);
      write_register(CSR_INTEGRAL_LOWER, lower);
      write_register(CSR_OUTPUT_LIMIT, cap);
      write_register(3'd6, CFG_W'($urandom));
      write_register(3'd7, CFG_W'($urandom));
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_request(input logic signed [DATA_W-1:0] setpoint,
                               input logic signed [DATA_W-1:0] measurement,
                               input logic known,
                               input logic signed [DATA_W-1:0] value);
      request_rows.push_back('{setpoint, measurement, known, value});
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_setpoint    <= setpoint;
      req_measurement <= measurement;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (control_expected.size() != 0 || request_rows.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   // half tracking loops near the setpoint, the rest full-range and corner values
   task automatic random_burst(input int count);
      logic signed [DATA_W-1:0] sp;
      logic signed [DATA_W-1:0] ms;
      int                       pick;
      logic signed [DATA_W-1:0] corners [4];
      corners = '{16'sd32767, 16'sh8000, 16'sd0, -16'sd1};
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            sp = DATA_W'($urandom);
            ms = DATA_W'($urandom);
         end else if (pick < 80) begin
            sp = DATA_W'($urandom_range(0, 16383)) - 16'sd8192;
            ms = sp + DATA_W'($urandom_range(0, 511)) - 16'sd256;
         end else begin
            sp = corners[$urandom_range(0, 3)];
            ms = corners[$urandom_range(0, 3)];
         end
         send_request(sp, ms, 1'b0, '0);
      end
      drain();
   endtask

   // receiver, with one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            repeat (HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 20);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (control_expected.size() == 0) begin
               $display("%0t: control_output expected none, actual %0d",
                        $time, rsp_control_output);
               mismatch_count++;
            end else begin
               wanted_output = control_expected.pop_front();
               if (rsp_control_output !== wanted_output) begin
                  $display("%0t: control_output expected %0d, actual %0d",
                           $time, wanted_output, rsp_control_output);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            wanted_output = predict_control(req_setpoint, req_measurement);
            if (request_rows.size() != 0) begin
               accepted_row = request_rows.pop_front();
               if (accepted_row.known) begin
                  wanted_output = accepted_row.value;
               end
            end
            control_expected.push_back(wanted_output);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_pi_controller_clamped: FAIL");
         $finish;
      end
   end

   initial begin
      gain_kp        = RST_PROPORTIONAL_GAIN;
      time_ti        = RST_INTEGRAL_TIME;
      period_ts      = RST_SAMPLE_PERIOD;
      bound_upper    = RST_INTEGRAL_UPPER;
      bound_lower    = RST_INTEGRAL_LOWER;
      output_cap     = RST_OUTPUT_LIMIT;
      integral_image = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         send_request(directed_rows[n].setpoint, directed_rows[n].measurement,
                      directed_rows[n].known, directed_rows[n].value);
      end
      drain();
      random_burst(40);

      // largest gains, widest bounds, limit written with the top bit set
      set_config(16'hFFFF, 16'd1, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF);
      random_burst(30);
      // zero integral time with zero output limit
      set_config(16'd256, 16'd0, 16'd256, 16'd12800, 16'hEC00, 16'd0);
      random_burst(20);
      // no gain, longest integral time
      set_config(16'd0, 16'hFFFF, 16'd0, 16'd12800, 16'hEC00, 16'd17920);
      random_burst(20);
      // crossed integral bounds
      set_config(16'd256, 16'd256, 16'd256, 16'hFC18, 16'd1000, 16'd17920);
      random_burst(20);

      set_config(16'd64, 16'd8192, 16'd32, 16'd2560, 16'hF600, 16'd6000);
      quiet = 1'b1;
      random_burst(60);
      quiet = 1'b0;

      set_config(16'd128, 16'd2048, 16'd128, 16'd6400, 16'hE700, 16'd12000);
      hold_pending = 1'b1;
      random_burst(40);

      repeat (8) begin
         logic [CFG_W-1:0] kp_pick;
         logic [CFG_W-1:0] ti_pick;
         logic [CFG_W-1:0] ts_pick;
         kp_pick = ($urandom_range(0, 3) != 0) ? CFG_W'($urandom_range(0, 1023))
                                               : CFG_W'($urandom_range(0, 65535));
         ti_pick = ($urandom_range(0, 3) != 0) ? CFG_W'($urandom_range(0, 65535))
                                               : CFG_W'($urandom_range(0, 15));
         ts_pick = ($urandom_range(0, 3) != 0) ? CFG_W'($urandom_range(0, 1023))
                                               : CFG_W'($urandom_range(0, 65535));
         set_config(kp_pick, ti_pick, ts_pick,
                    CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
         random_burst(40);
      end

      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && control_expected.size() == 0) begin
         $display("tb_pi_controller_clamped: PASS");
      end else begin
         $display("tb_pi_controller_clamped: FAIL");
      end
      $finish;
   end

endmodule
